[hdl/dpc_pkg.sv]
`timescale 1ns / 1ps
package dpc_pkg;

   localparam int MAX_POINTS = 1024;
   localparam int IDX_W      = $clog2(MAX_POINTS);
   localparam int CNT_W      = IDX_W + 1;
   localparam int COORD_W    = 16;
   localparam int DIFF_W     = COORD_W + 1;
   localparam int SQ_W       = 2 * DIFF_W;
   localparam int RAD_W      = 36;
   localparam int LAB_W      = 11;
   localparam int MINN_W     = 11;
   localparam int STATUS_W   = 2;
   localparam int CSR_IDX_W  = 1;

   localparam logic CMD_LOAD = 1'b0;
   localparam logic CMD_READ = 1'b1;

   localparam logic [CSR_IDX_W-1:0] CSR_MIN_NEIGHBOURS = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_RADIUS_SQUARED = 1'd1;

   localparam logic [STATUS_W-1:0] STATUS_OK       = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_OVERFLOW = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_RANGE    = 2'd2;

   localparam logic [MINN_W-1:0] MIN_NEIGHBOURS_RESET = 11'd4;
   localparam logic [RAD_W-1:0]  RADIUS_RESET        = 36'd65536;

   typedef struct packed {
      logic                      cmd;
      logic signed [COORD_W-1:0] x_pos;
      logic signed [COORD_W-1:0] y_pos;
      logic signed [COORD_W-1:0] z_pos;
      logic                      final_point;
      logic [IDX_W-1:0]          read_index;
   } req_type;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [LAB_W-1:0]    cluster_total;
      logic [IDX_W-1:0]    point_number;
      logic [LAB_W-1:0]    label;
   } rsp_type;

   typedef enum logic [1:0] {
      SCAN_COUNT,
      SCAN_MARK,
      SCAN_EXPAND
   } scan_mode_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_RD_RSP,
      ST_P_READ,
      ST_P_CHECK,
      ST_P_CNT_WAIT,
      ST_P_DECIDE,
      ST_P_MARK_WAIT,
      ST_SEED_NEXT,
      ST_SEED_WAIT,
      ST_SEED_LATCH,
      ST_S_CNT_WAIT,
      ST_S_DECIDE,
      ST_S_EXP_WAIT,
      ST_P_NEXT,
      ST_FIN_RSP
   } state_type;

   typedef struct packed {
      logic          load_en;
      logic          read_en;
      logic          p_clear;
      logic          p_inc;
      logic          rd_p;
      logic          latch_center;
      logic          scan_start;
      scan_mode_type scan_mode;
      logic          write_noncore;
      logic          q_clear;
      logic          seed_rd;
      logic          rd_seed_ctr;
      logic          clu_inc;
      logic          rsp_load_read;
      logic          rsp_load_final;
      logic          set_done;
   } ctrl_cmd_type;

   typedef struct packed {
      logic vis_p;
      logic p_last;
      logic scan_busy;
      logic core;
      logic q_more;
      logic rsp_free;
   } ctrl_sts_type;

endpackage

[hdl/dpc_controller.sv]
`timescale 1ns / 1ps
module dpc_controller (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  logic                  req_cmd,
   input  logic                  req_final,
   input  dpc_pkg::ctrl_sts_type sts,
   output logic                  req_stall,
   output dpc_pkg::ctrl_cmd_type cmd
);

   dpc_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= dpc_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         dpc_pkg::ST_IDLE: begin
            if (req_valid && req_cmd == dpc_pkg::CMD_READ) begin
               state_in = dpc_pkg::ST_RD_RSP;
            end else if (req_valid && req_final) begin
               state_in = dpc_pkg::ST_P_READ;
            end
         end
         dpc_pkg::ST_RD_RSP:      if (sts.rsp_free) state_in = dpc_pkg::ST_IDLE;
         dpc_pkg::ST_P_READ:      state_in = dpc_pkg::ST_P_CHECK;
         dpc_pkg::ST_P_CHECK:     state_in = sts.vis_p ? dpc_pkg::ST_P_NEXT
                                                       : dpc_pkg::ST_P_CNT_WAIT;
         dpc_pkg::ST_P_CNT_WAIT:  if (!sts.scan_busy) state_in = dpc_pkg::ST_P_DECIDE;
         dpc_pkg::ST_P_DECIDE:    state_in = sts.core ? dpc_pkg::ST_P_MARK_WAIT
                                                      : dpc_pkg::ST_P_NEXT;
         dpc_pkg::ST_P_MARK_WAIT: if (!sts.scan_busy) state_in = dpc_pkg::ST_SEED_NEXT;
         dpc_pkg::ST_SEED_NEXT:   state_in = sts.q_more ? dpc_pkg::ST_SEED_WAIT
                                                        : dpc_pkg::ST_P_NEXT;
         dpc_pkg::ST_SEED_WAIT:   state_in = dpc_pkg::ST_SEED_LATCH;
         dpc_pkg::ST_SEED_LATCH:  state_in = dpc_pkg::ST_S_CNT_WAIT;
         dpc_pkg::ST_S_CNT_WAIT:  if (!sts.scan_busy) state_in = dpc_pkg::ST_S_DECIDE;
         dpc_pkg::ST_S_DECIDE:    state_in = sts.core ? dpc_pkg::ST_S_EXP_WAIT
                                                      : dpc_pkg::ST_SEED_NEXT;
         dpc_pkg::ST_S_EXP_WAIT:  if (!sts.scan_busy) state_in = dpc_pkg::ST_SEED_NEXT;
         dpc_pkg::ST_P_NEXT:      state_in = sts.p_last ? dpc_pkg::ST_FIN_RSP
                                                        : dpc_pkg::ST_P_READ;
         dpc_pkg::ST_FIN_RSP:     if (sts.rsp_free) state_in = dpc_pkg::ST_IDLE;
         default:                 state_in = dpc_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      cmd       = '0;
      req_stall = (state_ff != dpc_pkg::ST_IDLE);
      unique case (state_ff)
         dpc_pkg::ST_IDLE: begin
            cmd.load_en = req_valid && (req_cmd == dpc_pkg::CMD_LOAD);
            cmd.read_en = req_valid && (req_cmd == dpc_pkg::CMD_READ);
            cmd.p_clear = req_valid && (req_cmd == dpc_pkg::CMD_LOAD) && req_final;
         end
         dpc_pkg::ST_RD_RSP:  cmd.rsp_load_read = sts.rsp_free;
         dpc_pkg::ST_P_READ:  cmd.rd_p = 1'b1;
         dpc_pkg::ST_P_CHECK: begin
            cmd.latch_center = !sts.vis_p;
            cmd.scan_start   = !sts.vis_p;
            cmd.scan_mode    = dpc_pkg::SCAN_COUNT;
         end
         dpc_pkg::ST_P_DECIDE: begin
            cmd.q_clear       = sts.core;
            cmd.scan_start    = sts.core;
            cmd.scan_mode     = dpc_pkg::SCAN_MARK;
            cmd.write_noncore = !sts.core;
         end
         dpc_pkg::ST_SEED_NEXT: begin
            cmd.seed_rd = sts.q_more;
            cmd.clu_inc = !sts.q_more;
         end
         dpc_pkg::ST_SEED_WAIT: cmd.rd_seed_ctr = 1'b1;
         dpc_pkg::ST_SEED_LATCH: begin
            cmd.latch_center = 1'b1;
            cmd.scan_start   = 1'b1;
            cmd.scan_mode    = dpc_pkg::SCAN_COUNT;
         end
         dpc_pkg::ST_S_DECIDE: begin
            cmd.scan_start = sts.core;
            cmd.scan_mode  = dpc_pkg::SCAN_EXPAND;
         end
         dpc_pkg::ST_P_NEXT: cmd.p_inc = !sts.p_last;
         dpc_pkg::ST_FIN_RSP: begin
            cmd.rsp_load_final = sts.rsp_free;
            cmd.set_done       = sts.rsp_free;
         end
         default: cmd = '0;
      endcase
   end

endmodule

[hdl/dpc_datapath.sv]
`timescale 1ns / 1ps
module dpc_datapath (
   input  logic                                clock,
   input  logic                                reset,
   input  dpc_pkg::req_type                    req_payload,
   input  logic                                csr_wr_en,
   input  logic [dpc_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [dpc_pkg::RAD_W-1:0]           csr_wr_data,
   input  dpc_pkg::ctrl_cmd_type               cmd,
   output dpc_pkg::ctrl_sts_type               sts,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output dpc_pkg::rsp_type                    rsp_payload
);

   localparam int IW = dpc_pkg::IDX_W;
   localparam int CW = dpc_pkg::CNT_W;
   localparam int XW = dpc_pkg::COORD_W;
   localparam int LW = dpc_pkg::LAB_W;
   localparam int SW = dpc_pkg::SQ_W;
   localparam int RW = dpc_pkg::RAD_W;

   // label store entry: visited bit over the label
   logic [3*XW-1:0] coord_mem [dpc_pkg::MAX_POINTS];
   logic [LW:0]     label_mem [dpc_pkg::MAX_POINTS];
   logic [IW-1:0]   seed_mem  [dpc_pkg::MAX_POINTS];

   logic [dpc_pkg::MINN_W-1:0] min_nbr_ff;
   logic [RW-1:0]              radius_ff;
   logic [CW-1:0] point_count_ff, next_cluster_ff;
   logic          overflow_ff, cloud_done_ff;
   logic [IW-1:0] p_ff;
   logic [CW-1:0] head_ff, qlen_ff;
   logic signed [XW-1:0] cx_ff, cy_ff, cz_ff;
   logic [IW-1:0] center_idx_ff, coord_addr_ff;
   logic [3*XW-1:0] coord_rd_ff;
   logic [LW:0]     lab_rd_ff;
   logic [IW-1:0]   seed_rd_ff;
   logic                   scan_on_ff;
   logic [CW-1:0]          scan_i_ff;
   dpc_pkg::scan_mode_type scan_mode_ff;
   logic          s1_valid_ff, s2_valid_ff;
   logic [IW-1:0] s1_idx_ff, s2_idx_ff;
   logic [SW-1:0] sq_x_ff, sq_y_ff, sq_z_ff;
   logic [LW:0]   s2_lab_ff;
   logic [CW-1:0] nbr_cnt_ff;
   logic [IW-1:0] rd_idx_ff;
   logic          rd_range_ff;
   logic          rsp_valid_ff;
   dpc_pkg::rsp_type rsp_ff;

   logic [CW-1:0] eff_count;
   logic          has_room;
   logic          coord_re, lab_re;
   logic [IW-1:0] coord_ra, lab_ra;
   logic          lab_we;
   logic [IW-1:0] lab_wa;
   logic [LW:0]   lab_wd;
   logic [RW-1:0] sq_dist;
   logic          near, lab_known, act_write, push, cnt_inc;
   logic [LW-1:0] cluster_total;

   function automatic logic [dpc_pkg::DIFF_W-1:0] abs_diff(
      input logic signed [dpc_pkg::COORD_W-1:0] a,
      input logic signed [dpc_pkg::COORD_W-1:0] b
   );
      logic signed [dpc_pkg::DIFF_W-1:0] d;
      d = {a[dpc_pkg::COORD_W-1], a} - {b[dpc_pkg::COORD_W-1], b};
      return d[dpc_pkg::DIFF_W-1] ? -d : d;
   endfunction

   assign eff_count     = cloud_done_ff ? '0 : point_count_ff;
   assign has_room      = (eff_count < CW'(dpc_pkg::MAX_POINTS));
   assign cluster_total = next_cluster_ff - 1'b1;

   assign sq_dist = RW'(sq_x_ff) + RW'(sq_y_ff) + RW'(sq_z_ff);
   assign near = s2_valid_ff && (sq_dist <= radius_ff);
   assign lab_known = s2_lab_ff[LW] && (s2_lab_ff[LW-1:0] != '0);

   always_comb begin
      act_write = 1'b0;
      push      = 1'b0;
      cnt_inc   = 1'b0;
      case (scan_mode_ff)
         dpc_pkg::SCAN_COUNT: cnt_inc = near;
         dpc_pkg::SCAN_MARK: begin
            act_write = near;
            push      = near && (s2_idx_ff != center_idx_ff) && !qlen_ff[IW];
         end
         dpc_pkg::SCAN_EXPAND: begin
            act_write = near && !lab_known;
            push      = near && !lab_known && !s2_lab_ff[LW] && !qlen_ff[IW];
         end
         default: act_write = 1'b0;
      endcase
   end

   // read port selection
   always_comb begin
      coord_re = 1'b0;
      coord_ra = p_ff;
      lab_re   = 1'b0;
      lab_ra   = p_ff;
      if (scan_on_ff) begin
         coord_re = 1'b1;
         coord_ra = scan_i_ff[IW-1:0];
         lab_re   = 1'b1;
         lab_ra   = scan_i_ff[IW-1:0];
      end else if (cmd.rd_p) begin
         coord_re = 1'b1;
         lab_re   = 1'b1;
      end else if (cmd.rd_seed_ctr) begin
         coord_re = 1'b1;
         coord_ra = seed_rd_ff;
      end else if (cmd.read_en) begin
         lab_re = 1'b1;
         lab_ra = req_payload.read_index;
      end
   end

   // write port selection
   always_comb begin
      lab_we = 1'b0;
      lab_wa = s2_idx_ff;
      lab_wd = {1'b1, next_cluster_ff};
      if (cmd.load_en && has_room) begin
         lab_we = 1'b1;
         lab_wa = eff_count[IW-1:0];
         lab_wd = '0;
      end else if (cmd.write_noncore) begin
         lab_we = 1'b1;
         lab_wa = center_idx_ff;
         lab_wd = {1'b1, {LW{1'b0}}};
      end else if (act_write) begin
         lab_we = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_en && has_room) begin
         coord_mem[eff_count[IW-1:0]] <= {req_payload.x_pos, req_payload.y_pos,
                                          req_payload.z_pos};
      end
      if (coord_re) begin
         coord_rd_ff <= coord_mem[coord_ra];
      end
      if (lab_we) begin
         label_mem[lab_wa] <= lab_wd;
      end
      if (lab_re) begin
         lab_rd_ff <= label_mem[lab_ra];
      end
      if (push) begin
         seed_mem[qlen_ff[IW-1:0]] <= s2_idx_ff;
      end
      if (cmd.seed_rd) begin
         seed_rd_ff <= seed_mem[head_ff[IW-1:0]];
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (coord_re) begin
         coord_addr_ff <= coord_ra;
      end
      if (cmd.latch_center) begin
         cx_ff         <= coord_rd_ff[3*XW-1:2*XW];
         cy_ff         <= coord_rd_ff[2*XW-1:XW];
         cz_ff         <= coord_rd_ff[XW-1:0];
         center_idx_ff <= coord_addr_ff;
      end
      if (cmd.read_en) begin
         rd_idx_ff   <= req_payload.read_index;
         rd_range_ff <= (CW'(req_payload.read_index) >= point_count_ff);
      end
      s1_idx_ff <= scan_i_ff[IW-1:0];
      s2_idx_ff <= s1_idx_ff;
      s2_lab_ff <= lab_rd_ff;
      sq_x_ff   <= SW'(abs_diff(cx_ff, coord_rd_ff[3*XW-1:2*XW]))
                 * SW'(abs_diff(cx_ff, coord_rd_ff[3*XW-1:2*XW]));
      sq_y_ff   <= SW'(abs_diff(cy_ff, coord_rd_ff[2*XW-1:XW]))
                 * SW'(abs_diff(cy_ff, coord_rd_ff[2*XW-1:XW]));
      sq_z_ff   <= SW'(abs_diff(cz_ff, coord_rd_ff[XW-1:0]))
                 * SW'(abs_diff(cz_ff, coord_rd_ff[XW-1:0]));
      if (cmd.rsp_load_final) begin
         rsp_ff.status        <= overflow_ff ? dpc_pkg::STATUS_OVERFLOW : dpc_pkg::STATUS_OK;
         rsp_ff.cluster_total <= cluster_total;
         rsp_ff.point_number  <= '0;
         rsp_ff.label         <= '0;
      end else if (cmd.rsp_load_read) begin
         rsp_ff.status        <= rd_range_ff ? dpc_pkg::STATUS_RANGE
                               : (overflow_ff ? dpc_pkg::STATUS_OVERFLOW
                                              : dpc_pkg::STATUS_OK);
         rsp_ff.cluster_total <= cluster_total;
         rsp_ff.point_number  <= rd_idx_ff;
         rsp_ff.label         <= rd_range_ff ? '0 : lab_rd_ff[LW-1:0];
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         min_nbr_ff      <= dpc_pkg::MIN_NEIGHBOURS_RESET;
         radius_ff       <= dpc_pkg::RADIUS_RESET;
         point_count_ff  <= '0;
         next_cluster_ff <= CW'(1);
         overflow_ff     <= 1'b0;
         cloud_done_ff   <= 1'b0;
         p_ff            <= '0;
         head_ff         <= '0;
         qlen_ff         <= '0;
         scan_on_ff      <= 1'b0;
         scan_i_ff       <= '0;
         scan_mode_ff    <= dpc_pkg::SCAN_COUNT;
         s1_valid_ff     <= 1'b0;
         s2_valid_ff     <= 1'b0;
         nbr_cnt_ff      <= '0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            unique case (csr_index)
               dpc_pkg::CSR_MIN_NEIGHBOURS: min_nbr_ff <= csr_wr_data[dpc_pkg::MINN_W-1:0];
               dpc_pkg::CSR_RADIUS_SQUARED: radius_ff  <= csr_wr_data;
               default: radius_ff <= radius_ff;
            endcase
         end
         if (cmd.load_en) begin
            point_count_ff  <= has_room ? eff_count + 1'b1 : eff_count;
            overflow_ff     <= (overflow_ff && !cloud_done_ff) || !has_room;
            next_cluster_ff <= cloud_done_ff ? CW'(1) : next_cluster_ff;
            cloud_done_ff   <= 1'b0;
         end else begin
            if (cmd.clu_inc) begin
               next_cluster_ff <= next_cluster_ff + 1'b1;
            end
            if (cmd.set_done) begin
               cloud_done_ff <= 1'b1;
            end
         end
         if (cmd.p_clear) begin
            p_ff <= '0;
         end else if (cmd.p_inc) begin
            p_ff <= p_ff + 1'b1;
         end
         if (cmd.q_clear) begin
            qlen_ff <= '0;
            head_ff <= '0;
         end else begin
            if (push) qlen_ff <= qlen_ff + 1'b1;
            if (cmd.seed_rd) head_ff <= head_ff + 1'b1;
         end
         // issue one index a cycle, then drain the two stages behind it
         if (cmd.scan_start) begin
            scan_on_ff   <= 1'b1;
            scan_i_ff    <= '0;
            scan_mode_ff <= cmd.scan_mode;
            nbr_cnt_ff   <= '0;
         end else if (scan_on_ff) begin
            scan_i_ff <= scan_i_ff + 1'b1;
            if (scan_i_ff + 1'b1 == point_count_ff) begin
               scan_on_ff <= 1'b0;
            end
         end
         if (cnt_inc) begin
            nbr_cnt_ff <= nbr_cnt_ff + 1'b1;
         end
         s1_valid_ff <= scan_on_ff;
         s2_valid_ff <= s1_valid_ff;
         if (cmd.rsp_load_final || cmd.rsp_load_read) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign sts.vis_p     = lab_rd_ff[LW];
   assign sts.p_last    = (CW'(p_ff) + 1'b1 >= point_count_ff);
   assign sts.scan_busy = scan_on_ff || s1_valid_ff || s2_valid_ff;
   assign sts.core      = (nbr_cnt_ff >= min_nbr_ff);
   assign sts.q_more    = (head_ff < qlen_ff);
   assign sts.rsp_free  = !rsp_valid_ff || !rsp_stall;

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

endmodule

[hdl/dbscan_point_clustering_unit.sv]
`timescale 1ns / 1ps
// Loads are taken one point a cycle while the block is idle; a label read is answered
// through the label read register and then the result register, once that is free. The
// load that carries final_point starts the clustering pass, during which no request is
// taken. The pass is bounded by the single coordinate read port: every neighbourhood
// query walks all N stored points at one a cycle through the read and squaring
// registers, and each visit to a point costs a core count walk and, if it is core, a
// marking or expansion walk.
// The result register lets a new request be taken while an answer waits on rsp_stall.
module dbscan_point_clustering_unit (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  dpc_pkg::req_type                  req_payload,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output dpc_pkg::rsp_type                  rsp_payload,
   input  logic                              csr_wr_en,
   input  logic [dpc_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [dpc_pkg::RAD_W-1:0]         csr_wr_data
);

   dpc_pkg::ctrl_cmd_type cmd;
   dpc_pkg::ctrl_sts_type sts;

   dpc_controller u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_cmd   (req_payload.cmd),
      .req_final (req_payload.final_point),
      .sts       (sts),
      .req_stall (req_stall),
      .cmd       (cmd)
   );

   dpc_datapath u_dp (
      .clock       (clock),
      .reset       (reset),
      .req_payload (req_payload),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data),
      .cmd         (cmd),
      .sts         (sts),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

endmodule

[hdl/dpc_checker.sv]
`timescale 1ns / 1ps
module dpc_checker (
   input logic             clock,
   input logic             reset,
   input logic             rsp_valid,
   input logic             rsp_stall,
   input dpc_pkg::rsp_type rsp_payload
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_payload))
      else $error("stalled result beat changed");

   a_range_label: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.status == dpc_pkg::STATUS_RANGE |-> rsp_payload.label == '0)
      else $error("out-of-range read carries a label");

   a_label_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_payload.label <= rsp_payload.cluster_total)
      else $error("label above cluster count");

   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_payload.status == dpc_pkg::STATUS_OK
                 || rsp_payload.status == dpc_pkg::STATUS_OVERFLOW
                 || rsp_payload.status == dpc_pkg::STATUS_RANGE)
      else $error("undefined status code");

endmodule

bind dbscan_point_clustering_unit dpc_checker u_dpc_checker (
   .clock       (clock),
   .reset       (reset),
   .rsp_valid   (rsp_valid),
   .rsp_stall   (rsp_stall),
   .rsp_payload (rsp_payload)
);

[test/tb_dbscan_point_clustering_unit.sv]
`timescale 1ns / 1ps
module tb_dbscan_point_clustering_unit;

   localparam longint CYCLE_LIMIT = 10_000_000;

   logic                          clock;
   logic                          reset;
   logic                          req_valid;
   logic                          req_stall;
   dpc_pkg::req_type              req_payload;
   logic                          rsp_valid;
   logic                          rsp_stall;
   dpc_pkg::rsp_type              rsp_payload;
   logic                          csr_wr_en;
   logic [dpc_pkg::CSR_IDX_W-1:0] csr_index;
   logic [dpc_pkg::RAD_W-1:0]     csr_wr_data;

   dbscan_point_clustering_unit u_top (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data)
   );

   always begin
      clock = 1'b1;
      #6;
      clock = 1'b0;
      #6;
   end

   // shadow of the block: point store, labels and cloud bookkeeping
   logic signed [dpc_pkg::COORD_W-1:0] pt_x [dpc_pkg::MAX_POINTS];
   logic signed [dpc_pkg::COORD_W-1:0] pt_y [dpc_pkg::MAX_POINTS];
   logic signed [dpc_pkg::COORD_W-1:0] pt_z [dpc_pkg::MAX_POINTS];
   logic [dpc_pkg::LAB_W-1:0]          pt_label [dpc_pkg::MAX_POINTS];
   bit                                 pt_seen [dpc_pkg::MAX_POINTS];
   int unsigned                        pt_count;
   logic [dpc_pkg::LAB_W-1:0]          next_id;
   bit                                 dropped;
   bit                                 cloud_closed;
   logic [dpc_pkg::MINN_W-1:0]         min_pts;
   logic [dpc_pkg::RAD_W-1:0]          radius2;

   dpc_pkg::rsp_type pending_rsp[$];
   int      errors;
   bit      quiet;
   longint  cycles;
   int      stall_left;

   function automatic bit close_pair(int a, int b);
      longint dx, dy, dz;
      longint unsigned d;
      dx = longint'(pt_x[a]) - longint'(pt_x[b]);
      dy = longint'(pt_y[a]) - longint'(pt_y[b]);
      dz = longint'(pt_z[a]) - longint'(pt_z[b]);
      d  = dx * dx + dy * dy + dz * dz;
      return d <= {28'd0, radius2};
   endfunction

   function automatic bit dense_point(int p);
      int cnt;
      cnt = 0;
      for (int i = 0; i < pt_count; i++)
         if (close_pair(p, i)) cnt++;
      return cnt >= min_pts;
   endfunction

   function automatic bit grow_cluster(int p, logic [dpc_pkg::LAB_W-1:0] id);
      int seeds[$];
      int head, s;
      if (!dense_point(p)) begin
         pt_seen[p]  = 1'b1;
         pt_label[p] = '0;
         return 1'b0;
      end
      for (int i = 0; i < pt_count; i++) begin
         if (close_pair(p, i)) begin
            pt_seen[i]  = 1'b1;
            pt_label[i] = id;
            if (i != p) seeds = {seeds, i};
         end
      end
      head = 0;
      while (head < seeds.size()) begin
         s = seeds[head];
         head++;
         if (!dense_point(s)) continue;
         for (int i = 0; i < pt_count; i++) begin
            if (!close_pair(s, i)) continue;
            // labelled points stay put; noise turns into a border point
            if (pt_seen[i] && pt_label[i] != 0) continue;
            if (!pt_seen[i]) seeds = {seeds, i};
            pt_seen[i]  = 1'b1;
            pt_label[i] = id;
         end
      end
      return 1'b1;
   endfunction

   function automatic void cluster_cloud();
      for (int p = 0; p < pt_count; p++) pt_seen[p] = 1'b0;
      for (int p = 0; p < pt_count; p++)
         if (!pt_seen[p] && grow_cluster(p, next_id)) next_id = next_id + 1'b1;
   endfunction

   function automatic void predict_beat(dpc_pkg::req_type r);
      dpc_pkg::rsp_type e;
      int idx;
      if (r.cmd == dpc_pkg::CMD_LOAD) begin
         if (cloud_closed) begin
            pt_count     = 0;
            dropped      = 1'b0;
            next_id      = 1;
            cloud_closed = 1'b0;
         end
         if (pt_count < dpc_pkg::MAX_POINTS) begin
            pt_x[pt_count]     = r.x_pos;
            pt_y[pt_count]     = r.y_pos;
            pt_z[pt_count]     = r.z_pos;
            pt_label[pt_count] = '0;
            pt_count++;
         end else begin
            dropped = 1'b1;
         end
         if (!r.final_point) return;
         cluster_cloud();
         cloud_closed    = 1'b1;
         e.status        = dropped ? dpc_pkg::STATUS_OVERFLOW : dpc_pkg::STATUS_OK;
         e.cluster_total = next_id - 1'b1;
         e.point_number  = '0;
         e.label         = '0;
      end else begin
         idx             = int'(r.read_index);
         e.cluster_total = next_id - 1'b1;
         e.point_number  = r.read_index;
         if (idx >= pt_count) begin
            e.status = dpc_pkg::STATUS_RANGE;
            e.label  = '0;
         end else begin
            e.status = dropped ? dpc_pkg::STATUS_OVERFLOW : dpc_pkg::STATUS_OK;
            e.label  = pt_label[idx];
         end
      end
      pending_rsp = {pending_rsp, e};
   endfunction

   task automatic report_mismatch(string field, longint got, longint want);
      $display("mismatch at cycle %0d: %s got %0d expected %0d", cycles, field, got, want);
      errors++;
   endtask

   always @(posedge clock) begin
      dpc_pkg::rsp_type e;
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("dbscan_point_clustering_unit verification failed");
         $finish;
      end
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_rsp.size() == 0) begin
            report_mismatch("unexpected result beat", 1, 0);
         end else begin
            e = pending_rsp.pop_front();
            if (rsp_payload.status != e.status)
               report_mismatch("status", longint'(rsp_payload.status), longint'(e.status));
            if (rsp_payload.cluster_total != e.cluster_total)
               report_mismatch("cluster_total", longint'(rsp_payload.cluster_total),
                               longint'(e.cluster_total));
            if (rsp_payload.point_number != e.point_number)
               report_mismatch("point_number", longint'(rsp_payload.point_number),
                               longint'(e.point_number));
            if (rsp_payload.label != e.label)
               report_mismatch("label", longint'(rsp_payload.label), longint'(e.label));
         end
      end
   end

   // result back-pressure in random bursts
   always @(posedge clock) begin
      if (reset || quiet) begin
         rsp_stall  <= 1'b0;
         stall_left = 0;
      end else if (stall_left > 0) begin
         stall_left--;
         if (stall_left == 0) rsp_stall <= 1'b0;
      end else if ($urandom_range(0, 9) == 0) begin
         stall_left = $urandom_range(1, 12);
         rsp_stall  <= 1'b1;
      end
   end

   task automatic send_beat(dpc_pkg::req_type r);
      if (!quiet && $urandom_range(0, 9) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 12)) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_payload <= r;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      predict_beat(r);
   endtask

   task automatic load_point(int x, int y, int z, bit last);
      dpc_pkg::req_type r;
      r             = '0;
      r.cmd         = dpc_pkg::CMD_LOAD;
      r.x_pos       = dpc_pkg::COORD_W'(x);
      r.y_pos       = dpc_pkg::COORD_W'(y);
      r.z_pos       = dpc_pkg::COORD_W'(z);
      r.final_point = last;
      r.read_index  = dpc_pkg::IDX_W'($urandom);
      send_beat(r);
   endtask

   task automatic read_label(int idx);
      dpc_pkg::req_type r;
      r             = '0;
      r.cmd         = dpc_pkg::CMD_READ;
      r.x_pos       = dpc_pkg::COORD_W'($urandom);
      r.y_pos       = dpc_pkg::COORD_W'($urandom);
      r.z_pos       = dpc_pkg::COORD_W'($urandom);
      r.final_point = 1'($urandom);
      r.read_index  = dpc_pkg::IDX_W'(idx);
      send_beat(r);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_rsp.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
   endtask

   task automatic write_csr(logic [dpc_pkg::CSR_IDX_W-1:0] idx, longint unsigned value);
      drain();
      csr_wr_en   <= 1'b1;
      csr_index   <= idx;
      csr_wr_data <= dpc_pkg::RAD_W'(value);
      @(posedge clock);
      csr_wr_en <= 1'b0;
      if (idx == dpc_pkg::CSR_MIN_NEIGHBOURS) min_pts = dpc_pkg::MINN_W'(value);
      else radius2 = dpc_pkg::RAD_W'(value);
   endtask

   task automatic test_reads_before_load();
      read_label(0);
      read_label(dpc_pkg::MAX_POINTS - 1);
   endtask

   task automatic test_extreme_cloud();
      load_point(-32768, -32768, -32768, 0);
      load_point(32767, 32767, 32767, 0);
      load_point(0, 0, 0, 0);
      read_label(1);
      load_point(100, 0, 0, 0);
      load_point(0, 100, 0, 0);
      load_point(0, 0, 100, 0);
      load_point(-32768, -32700, -32768, 1);
      for (int i = 0; i < 8; i++) read_label(i);
   endtask

   task automatic test_every_point_core();
      write_csr(dpc_pkg::CSR_MIN_NEIGHBOURS, 0);
      write_csr(dpc_pkg::CSR_RADIUS_SQUARED, 1);
      load_point(5, 5, 5, 0);
      load_point(5, 5, 6, 0);
      load_point(-7, 3, 2, 1);
      for (int i = 0; i < 4; i++) read_label(i);
   endtask

   task automatic test_register_extremes();
      write_csr(dpc_pkg::CSR_MIN_NEIGHBOURS, 64'h7FF);
      write_csr(dpc_pkg::CSR_RADIUS_SQUARED, 64'hF_FFFF_FFFF);
      for (int i = 0; i < 4; i++) load_point($urandom, $urandom, $urandom, i == 3);
      read_label(2);
      write_csr(dpc_pkg::CSR_MIN_NEIGHBOURS, 1);
      for (int i = 0; i < 4; i++) load_point($urandom, $urandom, $urandom, i == 3);
      read_label(3);
   endtask

   // chain-like clouds: random centres with tight spread so clusters actually form
   task automatic random_cloud(int n_pts);
      int cx, cy, cz, spread;
      spread = $urandom_range(20, 400);
      cx = int'($signed(16'($urandom)));
      cy = int'($signed(16'($urandom)));
      cz = int'($signed(16'($urandom)));
      for (int i = 0; i < n_pts; i++) begin
         if ($urandom_range(0, 4) == 0) begin
            cx = int'($signed(16'($urandom)));
            cy = int'($signed(16'($urandom)));
            cz = int'($signed(16'($urandom)));
         end
         if ($urandom_range(0, 7) == 0) read_label($urandom_range(0, i + 2));
         if ($urandom_range(0, 15) == 0)
            load_point($urandom, $urandom, $urandom, i == n_pts - 1);
         else
            load_point(cx + $urandom_range(0, 2 * spread) - spread,
                       cy + $urandom_range(0, 2 * spread) - spread,
                       cz + $urandom_range(0, 2 * spread) - spread, i == n_pts - 1);
      end
      repeat ($urandom_range(2, 8)) begin
         if ($urandom_range(0, 9) == 0) read_label($urandom);
         else read_label($urandom_range(0, n_pts));
      end
   endtask

   task automatic test_random_clouds(int beats);
      int sent, n_pts;
      sent = 0;
      while (sent < beats) begin
         if ($urandom_range(0, 2) == 0) begin
            write_csr(dpc_pkg::CSR_MIN_NEIGHBOURS, $urandom_range(1, 6));
            write_csr(dpc_pkg::CSR_RADIUS_SQUARED, $urandom_range(400, 400000));
         end
         n_pts = $urandom_range(1, 40);
         random_cloud(n_pts);
         sent += n_pts + n_pts / 8 + 5;
      end
   endtask

   task automatic test_overflow();
      // no point is ever core, so the pass is one count walk per point
      write_csr(dpc_pkg::CSR_MIN_NEIGHBOURS, 1024);
      write_csr(dpc_pkg::CSR_RADIUS_SQUARED, 1);
      for (int i = 0; i <= dpc_pkg::MAX_POINTS; i++)
         load_point($urandom, $urandom, i, i == dpc_pkg::MAX_POINTS);
      read_label(0);
      read_label(dpc_pkg::MAX_POINTS - 1);
      read_label($urandom);
   endtask

   initial begin
      errors       = 0;
      cycles       = 0;
      quiet        = 1'b0;
      stall_left   = 0;
      pt_count     = 0;
      next_id      = 1;
      dropped      = 1'b0;
      cloud_closed = 1'b0;
      min_pts      = dpc_pkg::MIN_NEIGHBOURS_RESET;
      radius2      = dpc_pkg::RADIUS_RESET;
      reset        <= 1'b1;
      req_valid    <= 1'b0;
      req_payload  <= '0;
      csr_wr_en    <= 1'b0;
      csr_index    <= '0;
      csr_wr_data  <= '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_reads_before_load();
      test_extreme_cloud();
      test_every_point_core();
      test_register_extremes();
      test_random_clouds(80);
      test_overflow();
      drain();
      quiet = 1'b1;
      test_random_clouds(40);

      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_rsp.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (errors == 0)
         $display("dbscan_point_clustering_unit verification clean");
      else
         $display("dbscan_point_clustering_unit verification failed");
      $finish;
   end

endmodule
